>>> rtl/mtm_pkg.sv
// multi timer manager package: mode codes, queue entry type, engine state type
// and sizing constants used by the front end, the command queue and the engine
package mtm_pkg;

  localparam int NumTimersDef = 8;
  localparam int TickBitsDef  = 32;
  localparam int IdxW         = 3;
  localparam int IvalW        = 32;

  typedef enum logic [2:0] {
    MODE_INIT  = 3'd0,
    MODE_START = 3'd1,
    MODE_STOP  = 3'd2,
    MODE_REM   = 3'd3,
    MODE_SET   = 3'd4,
    MODE_GET   = 3'd5,
    MODE_TICK  = 3'd6,
    MODE_NONE  = 3'd7
  } mode_t;

  // classified command word passed from front to back
  typedef struct packed {
    mode_t             mode;
    logic              bad_idx;
    logic [IdxW-1:0]   idx;
    logic [IvalW-1:0]  ival;
    logic              per;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARM_SCAN,
    ST_ARM_INS,
    ST_TICK_CHK,
    ST_OUT
  } eng_state_t;

endpackage

>>> rtl/mtm_front.sv
// front end: accepts input words, flags out-of-range indexes, two-entry queue
// depends on mtm_pkg
module mtm_front #(
  parameter int NUM_TIMERS = mtm_pkg::NumTimersDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,
  output logic                 q_valid,
  input  logic                 q_pop,
  output mtm_pkg::cmd_t        q_cmd
);

  mtm_pkg::cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  mtm_pkg::cmd_t c;
  logic push, pop;

  // classify incoming word
  always_comb begin
    c.mode    = mtm_pkg::mode_t'(in_tdata[2:0]);
    c.idx     = in_tdata[5:3];
    c.ival    = in_tdata[37:6];
    c.per     = in_tdata[38];
    c.bad_idx = (32'(in_tdata[5:3]) >= 32'(NUM_TIMERS));
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_cmd     = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= c;
  end

endmodule

>>> rtl/mtm_engine.sv
// timer engine: timer table, ordered link list and tick walk
// depends on mtm_pkg; fed by mtm_front
module mtm_engine #(
  parameter int NUM_TIMERS = mtm_pkg::NumTimersDef,
  parameter int TICK_BITS  = mtm_pkg::TickBitsDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_pop,
  input  mtm_pkg::cmd_t   q_cmd,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [39:0]     out_tdata,
  output logic            out_tlast
);

  localparam int PW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam int TW = TICK_BITS;

  logic [TW-1:0] now_r;
  logic [TW-1:0] ival_r [NUM_TIMERS];
  logic [TW-1:0] start_r [NUM_TIMERS];
  logic [TW-1:0] dl_r [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] per_r, act_r, lnk_r, rarm_r;
  logic [PW-1:0] ord_r [NUM_TIMERS];
  logic [CW-1:0] lcnt_r;

  mtm_pkg::eng_state_t st_r, st_nxt;
  logic [PW-1:0] tgt_r;
  logic [CW-1:0] pos_r;
  logic [CW-1:0] nrep_r;
  logic [2:0]    pend_r;
  logic [TW-1:0] mine_r;
  logic          is_tick_r;

  // output register
  logic        ov_r;
  logic        o_status_r, o_fired_r, o_last_r;
  logic [2:0]  o_idx_r;
  logic [31:0] o_ival_r;

  assign out_tvalid = ov_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {3'b0, o_ival_r, o_idx_r, o_fired_r, o_status_r};

  logic [PW-1:0] eidx, tidx;
  logic [TW-1:0] rem_e, elapsed;
  logic          head_ok;
  logic [PW-1:0] head_t;
  logic [PW-1:0] cidx;
  logic          oslot;
  logic          cmd_ok, cmd_status;
  logic [31:0]   cmd_ival;
  logic          tick_end, tick_fire;
  logic          o_load;
  logic [PW-1:0] ul_t;
  logic          ul_hit, ul_go;
  logic [PW-1:0] ul_ord [NUM_TIMERS];
  logic [PW-1:0] ins_ord [NUM_TIMERS];

  assign cidx  = PW'(q_cmd.idx);
  assign oslot = !ov_r || out_tready;
  assign eidx  = ord_r[pos_r[PW-1:0]];
  assign rem_e = dl_r[eidx] - now_r;

  // first linked timer not yet rearmed this tick
  always_comb begin
    head_ok = 1'b0;
    head_t  = '0;
    for (int j = NUM_TIMERS - 1; j >= 0; j--) begin
      if (CW'(j) < lcnt_r && !rarm_r[ord_r[j]]) begin
        head_ok = 1'b1;
        head_t  = ord_r[j];
      end
    end
  end
  assign tidx    = head_t;
  assign elapsed = now_r - start_r[tidx];

  // command classification and tick decision
  always_comb begin
    cmd_ok     = q_cmd.mode != mtm_pkg::MODE_TICK && q_cmd.mode != mtm_pkg::MODE_NONE &&
                 !q_cmd.bad_idx;
    cmd_status = q_cmd.mode != mtm_pkg::MODE_TICK && q_cmd.mode != mtm_pkg::MODE_NONE &&
                 (q_cmd.bad_idx || (q_cmd.mode == mtm_pkg::MODE_STOP && !act_r[cidx]));
    cmd_ival   = (cmd_ok && q_cmd.mode == mtm_pkg::MODE_GET) ? 32'(ival_r[cidx]) : '0;
    tick_end   = !head_ok || nrep_r == CW'(NUM_TIMERS) || elapsed < ival_r[tidx];
    tick_fire  = (st_r == mtm_pkg::ST_TICK_CHK) && oslot && !tick_end;
  end

  // list with one timer taken out
  always_comb begin
    ul_t   = (st_r == mtm_pkg::ST_TICK_CHK) ? tidx : cidx;
    ul_hit = 1'b0;
    for (int j = 0; j < NUM_TIMERS; j++) ul_ord[j] = ord_r[j];
    for (int j = 0; j < NUM_TIMERS - 1; j++) begin
      if (CW'(j) < lcnt_r && ord_r[j] == ul_t) ul_hit = 1'b1;
      if (ul_hit) ul_ord[j] = ord_r[j + 1];
    end
    ul_go = lnk_r[ul_t] && (tick_fire ||
            (st_r == mtm_pkg::ST_IDLE && q_pop && cmd_ok &&
             (q_cmd.mode == mtm_pkg::MODE_INIT || q_cmd.mode == mtm_pkg::MODE_START ||
              q_cmd.mode == mtm_pkg::MODE_REM ||
              (q_cmd.mode == mtm_pkg::MODE_STOP && act_r[cidx]))));
  end

  // list with the armed timer put in at the scan position
  always_comb begin
    for (int j = 0; j < NUM_TIMERS; j++) ins_ord[j] = ord_r[j];
    for (int j = 1; j < NUM_TIMERS; j++)
      if (CW'(j) > pos_r && CW'(j) <= lcnt_r) ins_ord[j] = ord_r[j - 1];
    ins_ord[pos_r[PW-1:0]] = tgt_r;
  end

  // sequencer next state
  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    o_load = 1'b0;
    unique case (st_r)
      mtm_pkg::ST_IDLE: begin
        if (q_valid && oslot) begin
          q_pop = 1'b1;
          if (q_cmd.mode == mtm_pkg::MODE_TICK) st_nxt = mtm_pkg::ST_TICK_CHK;
          else if (cmd_ok && q_cmd.mode == mtm_pkg::MODE_START) st_nxt = mtm_pkg::ST_ARM_SCAN;
          else st_nxt = mtm_pkg::ST_OUT;
        end
      end
      mtm_pkg::ST_ARM_SCAN: begin
        if (pos_r == lcnt_r || (dl_r[eidx] != dl_r[tgt_r] && rem_e > mine_r))
          st_nxt = mtm_pkg::ST_ARM_INS;
      end
      mtm_pkg::ST_ARM_INS: st_nxt = is_tick_r ? mtm_pkg::ST_TICK_CHK : mtm_pkg::ST_OUT;
      mtm_pkg::ST_TICK_CHK: begin
        if (oslot) begin
          if (tick_end) begin
            o_load = 1'b1;
            st_nxt = mtm_pkg::ST_IDLE;
          end else begin
            o_load = (nrep_r != '0);
            if (per_r[tidx] && act_r[tidx]) st_nxt = mtm_pkg::ST_ARM_SCAN;
          end
        end
      end
      mtm_pkg::ST_OUT: begin
        if (oslot) begin
          o_load = 1'b1;
          st_nxt = mtm_pkg::ST_IDLE;
        end
      end
      default: st_nxt = mtm_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= mtm_pkg::ST_IDLE;
    else st_r <= st_nxt;
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (o_load) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end

  // ordered link list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcnt_r <= '0;
      lnk_r  <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) ord_r[i] <= '0;
    end else if (ul_go) begin
      for (int i = 0; i < NUM_TIMERS; i++) ord_r[i] <= ul_ord[i];
      lcnt_r <= lcnt_r - 1'b1;
      lnk_r  <= lnk_r & ~(NUM_TIMERS'(1) << ul_t);
    end else if (st_r == mtm_pkg::ST_ARM_INS) begin
      for (int i = 0; i < NUM_TIMERS; i++) ord_r[i] <= ins_ord[i];
      lcnt_r <= lcnt_r + 1'b1;
      lnk_r  <= lnk_r | (NUM_TIMERS'(1) << tgt_r);
    end
  end

  // timer table, walk registers and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r  <= '0;
      per_r  <= '0;
      act_r  <= '0;
      rarm_r <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        ival_r[i]  <= '0;
        start_r[i] <= '0;
        dl_r[i]    <= '0;
      end
    end else begin
      unique case (st_r)
        mtm_pkg::ST_IDLE: begin
          if (q_pop) begin
            is_tick_r <= (q_cmd.mode == mtm_pkg::MODE_TICK);
            if (q_cmd.mode == mtm_pkg::MODE_TICK) begin
              now_r  <= now_r + 1'b1;
              rarm_r <= '0;
              nrep_r <= '0;
            end else begin
              o_status_r <= cmd_status;
              o_fired_r  <= 1'b0;
              o_idx_r    <= '0;
              o_ival_r   <= cmd_ival;
              o_last_r   <= 1'b1;
              if (cmd_ok) begin
                unique case (q_cmd.mode)
                  mtm_pkg::MODE_INIT: begin
                    per_r[cidx]   <= q_cmd.per;
                    act_r[cidx]   <= 1'b0;
                    start_r[cidx] <= '0;
                    dl_r[cidx]    <= '0;
                    ival_r[cidx]  <= TW'(q_cmd.ival);
                  end
                  mtm_pkg::MODE_START: begin
                    start_r[cidx] <= now_r;
                    dl_r[cidx]    <= now_r + ival_r[cidx];
                    mine_r        <= ival_r[cidx];
                    act_r[cidx]   <= 1'b1;
                    tgt_r         <= cidx;
                    pos_r         <= '0;
                  end
                  mtm_pkg::MODE_STOP: if (act_r[cidx]) act_r[cidx] <= 1'b0;
                  mtm_pkg::MODE_SET: ival_r[cidx] <= TW'(q_cmd.ival);
                  default: ;
                endcase
              end
            end
          end
        end
        // walk list to find insertion point, one entry a cycle
        mtm_pkg::ST_ARM_SCAN: begin
          if (st_nxt == mtm_pkg::ST_ARM_SCAN) pos_r <= pos_r + 1'b1;
        end
        // examine list head; the previous report leaves once the next step is known
        mtm_pkg::ST_TICK_CHK: begin
          if (oslot) begin
            o_status_r <= 1'b0;
            o_ival_r   <= '0;
            if (tick_end) begin
              o_fired_r <= (nrep_r != '0);
              o_idx_r   <= (nrep_r != '0) ? pend_r : 3'd0;
              o_last_r  <= 1'b1;
            end else begin
              o_fired_r <= 1'b1;
              o_idx_r   <= pend_r;
              o_last_r  <= 1'b0;
              pend_r    <= 3'(tidx);
              nrep_r    <= nrep_r + 1'b1;
              if (per_r[tidx] && act_r[tidx]) begin
                start_r[tidx] <= now_r;
                dl_r[tidx]    <= now_r + ival_r[tidx];
                mine_r        <= ival_r[tidx];
                rarm_r[tidx]  <= 1'b1;
                tgt_r         <= tidx;
                pos_r         <= '0;
              end else begin
                act_r[tidx] <= 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/multi_timer_manager_unit.sv
// multi timer manager top level: command front end and timer engine
// depends on mtm_pkg, mtm_front, mtm_engine
//
// usage: each input word on the in_ stream is one command (init, start, stop,
// remove, set interval, get interval, tick). other commands give one result
// word on the out_ stream; a tick gives one word per expired timer in
// deadline order (ties in arming order), or one empty word if none expired.
// out_tlast marks the final word of each command.
// a plain command's result is registered: the engine pops the word, moves to
// its output state and loads the result word before it takes the next word.
// a start walks the ordered list one entry a cycle, then inserts. a tick
// examines the list head timer by timer and, for each periodic rearm, walks
// the list and inserts that timer again. a two-word queue lets input words
// arrive while the engine works.
// reset clears the tick counter, all timers and the list.
// when the receiver stalls the engine holds its result and the queue fills,
// then in_tready drops.
module multi_timer_manager_unit #(
  parameter int NUM_TIMERS = mtm_pkg::NumTimersDef,
  parameter int TICK_BITS  = mtm_pkg::TickBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // mode, timer_index, interval, periodic
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status, fired, fired_index, interval_out
  output logic        out_tlast
);

  logic          q_valid, q_pop;
  mtm_pkg::cmd_t q_cmd;

  mtm_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .q_valid, .q_pop, .q_cmd
  );

  mtm_engine #(.NUM_TIMERS(NUM_TIMERS), .TICK_BITS(TICK_BITS)) u_engine (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

  // a pop only happens when a queued word exists
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop of empty queue");

  // a result is never dropped while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");

endmodule
